/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the serve motor sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, switched off while aresetn is low.
`define SMSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, also during reset.
`define SMSEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/smseq_pkg.sv */
// ---------------------------------------------------------------------------
// smseq_pkg
// Types, codes and constants shared by the serve motor sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package smseq_pkg;

    localparam int WIND_SPEED       = 1000;
    localparam int HOME_SPEED       = 1500;
    localparam int TICK_COUNT_BITS  = 16;
    localparam int ANGLE_FRAC_BITS  = 4;

    localparam int ANGLE_BITS = 13;
    localparam int VALUE_BITS = 16;
    localparam int ROT_BITS   = 17;
    localparam int CFG_BITS   = 16;
    localparam int CFG_COUNT  = 8;
    localparam int CFG_IDX_BITS = $clog2(CFG_COUNT);

    localparam logic [ANGLE_BITS-1:0] FULL_TURN = ANGLE_BITS'(360 << ANGLE_FRAC_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(180 << ANGLE_FRAC_BITS);

    localparam logic signed [VALUE_BITS-1:0] CUR_LIMIT_POS = 16'sd16384;
    localparam logic signed [VALUE_BITS-1:0] CUR_LIMIT_NEG = -16'sd16384;
    localparam logic signed [VALUE_BITS-1:0] CHARGE_RPM    = VALUE_BITS'(WIND_SPEED);
    localparam logic signed [VALUE_BITS-1:0] RETURN_RPM    = VALUE_BITS'(-HOME_SPEED);

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LOWER  = 3'd1;
    localparam logic [2:0] PH_WIND   = 3'd2;
    localparam logic [2:0] PH_DELAY  = 3'd3;
    localparam logic [2:0] PH_STRIKE = 3'd4;
    localparam logic [2:0] PH_RETURN = 3'd5;

    // Motor command modes
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_CURRENT = 2'd1;
    localparam logic [1:0] MODE_VEL     = 2'd2;
    localparam logic [1:0] MODE_POS     = 2'd3;

    // Arm commands
    localparam logic [1:0] ARM_NONE  = 2'd0;
    localparam logic [1:0] ARM_LOWER = 2'd1;
    localparam logic [1:0] ARM_RAISE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIND_TARGET      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHARGE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIKE_ROTATION  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETURN_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_TICKS      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIKE_TIMEOUT   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIT_CURRENT      = 3'd7;

    typedef struct packed {
        logic                  trigger_event;
        logic                  abort_event;
        logic                  arm_ready_event;
        logic                  angle_valid;
        logic [ANGLE_BITS-1:0] motor_angle;
    } in_t;

    typedef struct packed {
        logic [1:0]                   motor_mode;
        logic signed [VALUE_BITS-1:0] motor_value;
        logic [1:0]                   arm_command;
        logic [2:0]                   phase;
    } out_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        wind_target;
        logic [ANGLE_BITS-1:0]        charge_threshold;
        logic [15:0]                  strike_rotation;
        logic [ANGLE_BITS-1:0]        return_threshold;
        logic [15:0]                  arm_timeout_ticks;
        logic [15:0]                  delay_ticks;
        logic [15:0]                  strike_timeout_ticks;
        logic signed [VALUE_BITS-1:0] hit_current;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/smseq_cfg_regs.sv */
// ---------------------------------------------------------------------------
// smseq_cfg_regs
// Configuration register file with reset defaults and indexed writes.
// ---------------------------------------------------------------------------
`default_nettype none

module smseq_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [smseq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [smseq_pkg::CFG_BITS-1:0]     cfg_wdata,
    output smseq_pkg::cfg_t                         cfg
);
    import smseq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_WIND_TARGET:      cfg_next.wind_target          = cfg_wdata[ANGLE_BITS-1:0];
                CFG_CHARGE_THRESHOLD: cfg_next.charge_threshold     = cfg_wdata[ANGLE_BITS-1:0];
                CFG_STRIKE_ROTATION:  cfg_next.strike_rotation      = cfg_wdata;
                CFG_RETURN_THRESHOLD: cfg_next.return_threshold     = cfg_wdata[ANGLE_BITS-1:0];
                CFG_ARM_TIMEOUT:      cfg_next.arm_timeout_ticks    = cfg_wdata;
                CFG_DELAY_TICKS:      cfg_next.delay_ticks          = cfg_wdata;
                CFG_STRIKE_TIMEOUT:   cfg_next.strike_timeout_ticks = cfg_wdata;
                CFG_HIT_CURRENT:      cfg_next.hit_current          = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wind_target          <= 13'd3840;
            cfg_reg.charge_threshold     <= 13'd80;
            cfg_reg.strike_rotation      <= 16'd7200;
            cfg_reg.return_threshold     <= 13'd80;
            cfg_reg.arm_timeout_ticks    <= 16'd1000;
            cfg_reg.delay_ticks          <= 16'd60;
            cfg_reg.strike_timeout_ticks <= 16'd400;
            cfg_reg.hit_current          <= -16'sd16384;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/smseq_core.sv */
// ---------------------------------------------------------------------------
// smseq_core
// Phase sequencer state and the per-tick next-state and command logic.
// ---------------------------------------------------------------------------
`default_nettype none

module smseq_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire smseq_pkg::in_t  tick,
    input  wire smseq_pkg::cfg_t cfg,
    output smseq_pkg::out_t      result
);
    import smseq_pkg::*;

    logic [2:0]                 phase_reg, phase_next;
    logic [TICK_COUNT_BITS-1:0] ticks_reg, ticks_next;
    logic [ROT_BITS-1:0]        rot_reg, rot_next;
    logic [ANGLE_BITS-1:0]      prev_reg, prev_next;
    logic                       trig_pend_reg, trig_pend_next;
    logic                       arm_pend_reg, arm_pend_next;

    logic [ANGLE_BITS-1:0]        angle;
    logic [ANGLE_BITS-1:0]        charge;
    logic [ANGLE_BITS:0]          rem_diff;
    logic [ANGLE_BITS-1:0]        rem;
    logic [ANGLE_BITS:0]          ccw_diff;
    logic [ANGLE_BITS-1:0]        ccw_step;
    logic [ROT_BITS:0]            rot_sum;
    logic [ROT_BITS-1:0]          rot_upd;
    logic [TICK_COUNT_BITS-1:0]   ticks_inc;
    logic signed [VALUE_BITS-1:0] strike_value;

    // Angles are reduced modulo the full circle; one subtraction suffices for 13 bits.
    assign angle  = (tick.motor_angle >= FULL_TURN) ? tick.motor_angle - FULL_TURN
                                                    : tick.motor_angle;
    assign charge = (cfg.wind_target >= FULL_TURN) ? cfg.wind_target - FULL_TURN
                                                   : cfg.wind_target;

    assign rem_diff = {1'b0, charge} - {1'b0, angle};
    assign rem      = rem_diff[ANGLE_BITS] ? ANGLE_BITS'(rem_diff + {1'b0, FULL_TURN})
                                           : rem_diff[ANGLE_BITS-1:0];

    assign ccw_diff = {1'b0, prev_reg} - {1'b0, angle};
    assign ccw_step = ccw_diff[ANGLE_BITS] ? ANGLE_BITS'(ccw_diff + {1'b0, FULL_TURN})
                                           : ccw_diff[ANGLE_BITS-1:0];

    // Steps of half a turn or more are taken as clockwise and ignored.
    assign rot_sum = {1'b0, rot_reg} + (ROT_BITS+1)'(ccw_step);
    always_comb begin
        if (ccw_step >= HALF_TURN) begin
            rot_upd = rot_reg;
        end else if (rot_sum[ROT_BITS]) begin
            rot_upd = '1;
        end else begin
            rot_upd = rot_sum[ROT_BITS-1:0];
        end
    end

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + TICK_COUNT_BITS'(1);

    always_comb begin
        if (cfg.hit_current > CUR_LIMIT_POS) begin
            strike_value = CUR_LIMIT_POS;
        end else if (cfg.hit_current < CUR_LIMIT_NEG) begin
            strike_value = CUR_LIMIT_NEG;
        end else begin
            strike_value = cfg.hit_current;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        rot_next       = rot_reg;
        prev_next      = prev_reg;
        trig_pend_next = trig_pend_reg | tick.trigger_event;
        arm_pend_next  = arm_pend_reg | tick.arm_ready_event;
        result.motor_mode  = MODE_NONE;
        result.motor_value = '0;
        result.arm_command = ARM_NONE;

        if (tick.abort_event && (phase_reg != PH_IDLE)) begin
            phase_next = PH_RETURN;
            ticks_next = '0;
            prev_next  = angle;
            result.arm_command = ARM_RAISE;
        end else begin
            unique case (phase_reg)
                PH_LOWER: begin
                    ticks_next = ticks_inc;
                    if (arm_pend_next) begin
                        arm_pend_next = 1'b0;
                        phase_next    = PH_WIND;
                        ticks_next    = '0;
                    end else if (32'(ticks_inc) > 32'(cfg.arm_timeout_ticks)) begin
                        phase_next = PH_WIND;
                        ticks_next = '0;
                    end
                end
                PH_WIND: begin
                    ticks_next = ticks_inc;
                    if (tick.angle_valid) begin
                        if (rem < cfg.charge_threshold) begin
                            result.motor_mode  = MODE_POS;
                            result.motor_value = VALUE_BITS'(charge);
                            phase_next = PH_DELAY;
                            ticks_next = '0;
                        end else begin
                            result.motor_mode  = MODE_VEL;
                            result.motor_value = CHARGE_RPM;
                        end
                    end
                end
                PH_DELAY: begin
                    ticks_next = ticks_inc;
                    result.motor_mode  = MODE_POS;
                    result.motor_value = VALUE_BITS'(charge);
                    if (32'(ticks_inc) >= 32'(cfg.delay_ticks)) begin
                        phase_next = PH_STRIKE;
                        ticks_next = '0;
                        rot_next   = '0;
                        prev_next  = angle;
                    end
                end
                PH_STRIKE: begin
                    ticks_next = ticks_inc;
                    if (tick.angle_valid) begin
                        rot_next  = rot_upd;
                        prev_next = angle;
                        if ((rot_upd >= ROT_BITS'(cfg.strike_rotation)) ||
                            (32'(ticks_inc) >= 32'(cfg.strike_timeout_ticks))) begin
                            phase_next = PH_RETURN;
                            ticks_next = '0;
                            result.arm_command = ARM_RAISE;
                        end else begin
                            result.motor_mode  = MODE_CURRENT;
                            result.motor_value = strike_value;
                        end
                    end
                end
                PH_RETURN: begin
                    ticks_next = ticks_inc;
                    if (tick.angle_valid) begin
                        if (angle < cfg.return_threshold) begin
                            result.motor_mode  = MODE_POS;
                            result.motor_value = '0;
                            phase_next = PH_IDLE;
                            ticks_next = '0;
                        end else begin
                            result.motor_mode  = MODE_VEL;
                            result.motor_value = RETURN_RPM;
                        end
                    end
                end
                default: begin
                    // Idle, and any code that should never occur.
                    phase_next = PH_IDLE;
                    if (trig_pend_next) begin
                        trig_pend_next = 1'b0;
                        arm_pend_next  = 1'b0;
                        phase_next     = PH_LOWER;
                        ticks_next     = '0;
                        result.arm_command = ARM_LOWER;
                    end
                end
            endcase
        end
        result.phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            ticks_reg     <= '0;
            rot_reg       <= '0;
            prev_reg      <= '0;
            trig_pend_reg <= 1'b0;
            arm_pend_reg  <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            rot_reg       <= rot_next;
            prev_reg      <= prev_next;
            trig_pend_reg <= trig_pend_next;
            arm_pend_reg  <= arm_pend_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/serve_motor_sequencer.sv */
// ---------------------------------------------------------------------------
// serve_motor_sequencer
// Six-phase serve motor and catch arm sequencer, one control tick per transaction.
// ---------------------------------------------------------------------------
// Each input transaction is one control tick and yields exactly one result
// transaction. A tick is captured in an input register, the sequencer state is
// updated from it as the command lands in a result register, so the block takes
// one tick per clock cycle when the output is not stalled, and a result is
// presented on the m_ channel from that result register. While a finished
// result waits for m_ready, the input register can still take one more tick,
// after which s_ready stays low. Configuration registers are written through
// cfg_we, cfg_index and cfg_wdata and should only be changed while no tick is
// in flight.
`default_nettype none

module serve_motor_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire smseq_pkg::in_t                     s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output smseq_pkg::out_t                         m_data,
    input  wire logic                               cfg_we,
    input  wire logic [smseq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [smseq_pkg::CFG_BITS-1:0]     cfg_wdata
);
    import smseq_pkg::*;

    `include "assert_macros.svh"

    in_t  in_data_reg;
    logic in_valid_reg, in_valid_next;
    out_t out_data_reg;
    logic out_valid_reg, out_valid_next;

    cfg_t cfg;
    out_t result;
    logic step;
    logic take;

    smseq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    smseq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .tick    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // A held tick moves on whenever the result register is free or being emptied.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `SMSEQ_ASSERT(a_take_fills_stage, take |=> in_valid_reg, "accepted tick not held")
    `SMSEQ_ASSERT(a_step_gives_result, step |=> m_valid, "tick advanced without a result")
    `SMSEQ_ASSERT(a_phase_legal, m_valid |-> (m_data.phase <= PH_RETURN), "illegal phase code")
    `SMSEQ_ASSERT(a_raise_in_return,
        (m_valid && (m_data.arm_command == ARM_RAISE)) |-> (m_data.phase == PH_RETURN),
        "raise outside return")
    `SMSEQ_ASSERT(a_lower_in_lower,
        (m_valid && (m_data.arm_command == ARM_LOWER)) |-> (m_data.phase == PH_LOWER),
        "lower outside lower phase")
    `SMSEQ_ASSERT_ALWAYS(a_reset_empty, !$past(aresetn) |-> (!m_valid && s_ready),
        "pipeline not empty after reset")

endmodule

`default_nettype wire
